// ----- hdl/utcd_pkg.sv -----
package utcd_pkg;

  // Field widths of one time stamp and of one decoded result.
  localparam int unsigned MjdW   = 16;
  localparam int unsigned BcdW   = 24;
  localparam int unsigned YearW  = 11;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned TimeW  = 8;

  // Date conversion constants (integer form of the decimal MJD formula).
  localparam int unsigned MjdMinValid    = 15079;
  localparam int unsigned YearBase       = 1900;
  localparam int unsigned YearNumOffset  = 301564;
  localparam int unsigned YearDiv        = 7305;
  localparam int unsigned MjdEpoch       = 14956;
  localparam int unsigned DaysPer4Years  = 1461;
  localparam int unsigned MonthNumScale  = 10000;
  localparam int unsigned MonthNumOffset = 1000;
  localparam int unsigned MonthDiv       = 306001;

  // Internal widths of the date pipeline.
  localparam int unsigned NumW    = 20;  // 20*mjd - 301564
  localparam int unsigned RecipW  = 20;  // reciprocal of the year divisor
  localparam int unsigned RecipSh = 32;  // binary point of the reciprocal
  localparam int unsigned YIdxW   = 8;   // years since 1900
  localparam int unsigned YDivW   = 13;  // width of the year divisor
  localparam int unsigned RemW    = 10;  // day count inside the shifted year
  localparam int unsigned MdW     = 9;   // days before a shifted month
  localparam int unsigned NumMonthCodes = 16;

  localparam longint unsigned YearRecip = (64'd1 << RecipSh) / YearDiv;

  // Payload of one time stamp.
  typedef struct packed {
    logic [MjdW-1:0] mjd_value;
    logic [BcdW-1:0] bcd_time;
  } utcd_in_t;

  // Payload of one decoded result.
  typedef struct packed {
    logic [YearW-1:0]  year_out;
    logic [MonthW-1:0] month_out;
    logic [DayW-1:0]   day_out;
    logic [TimeW-1:0]  hour_out;
    logic [TimeW-1:0]  minute_out;
    logic [TimeW-1:0]  second_out;
    logic              date_valid;
    logic              time_valid;
  } utcd_out_t;

  typedef logic [RemW-1:0] rem_t;
  typedef rem_t [NumMonthCodes-1:0] thr_table_t;
  typedef logic [MdW-1:0] md_t;
  typedef md_t [NumMonthCodes-1:0] md_table_t;

  // Smallest day count for which the month code reaches k.
  function automatic thr_table_t month_thresholds();
    thr_table_t t;
    t = '0;
    for (int unsigned k = 1; k < NumMonthCodes; k++) begin
      t[k] = RemW'((MonthDiv * k + MonthNumOffset + MonthNumScale - 1) / MonthNumScale);
    end
    return t;
  endfunction

  // Days that precede month code k inside the shifted year.
  function automatic md_table_t month_offsets();
    md_table_t t;
    t = '0;
    for (int unsigned k = 0; k < NumMonthCodes; k++) begin
      t[k] = MdW'((MonthDiv * k) / MonthNumScale);
    end
    return t;
  endfunction

endpackage

// ----- hdl/utcd_in_if.sv -----
interface utcd_in_if import utcd_pkg::*; ();
  logic     valid;
  logic     ready;
  utcd_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/utcd_out_if.sv -----
interface utcd_out_if import utcd_pkg::*; ();
  logic      valid;
  logic      ready;
  utcd_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/utcd_date_pipe.sv -----
module utcd_date_pipe import utcd_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [MjdW-1:0]   mjd_i,
  output logic [YearW-1:0]  year_o,
  output logic [MonthW-1:0] month_o,
  output logic [DayW-1:0]   day_o,
  output logic              date_valid_o
);

  localparam thr_table_t MonthThr = month_thresholds();
  localparam md_table_t  MonthOff = month_offsets();

  // Stage 1: numerator of the year division and the validity test.
  logic [NumW:0]      mul20;
  logic [NumW-1:0]    num_d, num1_q;
  logic [MjdW-1:0]    mjd1_q;
  logic               dv1_q;

  assign mul20 = (NumW+1)'({mjd_i, 4'b0000}) + (NumW+1)'({mjd_i, 2'b00});
  assign num_d = NumW'(mul20 - (NumW+1)'(YearNumOffset));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num1_q <= num_d;
      mjd1_q <= mjd_i;
      dv1_q  <= (mjd_i >= MjdW'(MjdMinValid));
    end
  end

  // Stage 2: quotient estimate by the reciprocal, low by at most one.
  logic [NumW+RecipW-1:0] recip_prod;
  logic [YIdxW-1:0]       q0_q;
  logic [NumW-1:0]        num2_q;
  logic [MjdW-1:0]        mjd2_q;
  logic                   dv2_q;

  assign recip_prod = (NumW+RecipW)'(num1_q) * (NumW+RecipW)'(RecipW'(YearRecip));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q0_q   <= recip_prod[RecipSh +: YIdxW];
      num2_q <= num1_q;
      mjd2_q <= mjd1_q;
      dv2_q  <= dv1_q;
    end
  end

  // Stage 3: remainder check fixes the estimate to the exact year index.
  logic [NumW:0]      back_prod;
  logic [NumW:0]      year_rem;
  logic [YIdxW-1:0]   y_d, y3_q;
  logic [MjdW-1:0]    mjd3_q;
  logic               dv3_q;

  assign back_prod = (NumW+1)'(q0_q) * (NumW+1)'(YDivW'(YearDiv));
  assign year_rem  = (NumW+1)'(num2_q) - back_prod;
  assign y_d       = q0_q + YIdxW'(year_rem >= (NumW+1)'(YearDiv));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y3_q   <= y_d;
      mjd3_q <= mjd2_q;
      dv3_q  <= dv2_q;
    end
  end

  // Stage 4: days left after the whole years.
  localparam int unsigned YdW = YIdxW + 11;
  logic [YdW-1:0]   yd_prod;
  logic [MjdW:0]    rem_full;
  logic [RemW-1:0]  rem4_q;
  logic [YIdxW-1:0] y4_q;
  logic             dv4_q;

  assign yd_prod  = YdW'(y3_q) * YdW'(DaysPer4Years);
  assign rem_full = (MjdW+1)'(mjd3_q) - (MjdW+1)'(MjdEpoch)
                  - (MjdW+1)'(yd_prod[YdW-1:2]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem4_q <= rem_full[RemW-1:0];
      y4_q   <= y3_q;
      dv4_q  <= dv3_q;
    end
  end

  // Stage 5: month code from the day count by threshold compares.
  logic [MonthW-1:0] m_d, m5_q;
  logic [RemW-1:0]   rem5_q;
  logic [YIdxW-1:0]  y5_q;
  logic              dv5_q;

  always_comb begin
    m_d = '0;
    for (int unsigned k = 1; k < NumMonthCodes; k++) begin
      if (rem4_q >= MonthThr[k]) begin
        m_d = MonthW'(k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m5_q   <= m_d;
      rem5_q <= rem4_q;
      y5_q   <= y4_q;
      dv5_q  <= dv4_q;
    end
  end

  // Stage 6: day of month, January/February wrap, invalid date defaults.
  logic              wrap;
  logic [RemW-1:0]   day_full;
  logic [YearW-1:0]  year_d, year_q;
  logic [MonthW-1:0] month_d, month_q;
  logic [DayW-1:0]   day_d, day_q;
  logic              dv_q;

  assign wrap     = (m5_q == MonthW'(14)) || (m5_q == MonthW'(15));
  assign day_full = rem5_q - RemW'(MonthOff[m5_q]);

  always_comb begin
    if (dv5_q) begin
      year_d  = YearW'(YearBase) + YearW'(y5_q) + YearW'(wrap);
      month_d = wrap ? (m5_q - MonthW'(13)) : (m5_q - MonthW'(1));
      day_d   = day_full[DayW-1:0];
    end else begin
      year_d  = YearW'(YearBase);
      month_d = '0;
      day_d   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
      dv_q    <= dv5_q;
    end
  end

  assign year_o       = year_q;
  assign month_o      = month_q;
  assign day_o        = day_q;
  assign date_valid_o = dv_q;

endmodule

// ----- hdl/utc_time_mjd_bcd_decode_core.sv -----
// An accepted item passes through six registered stages to its result on the output port.
// One item per cycle while the output is not stalled; the six-stage date pipeline, whose year
// division is a reciprocal multiply plus one remainder check, sets the depth.
// All stages advance together whenever the output register is empty or taken.
// Reset clears only the stage valid bits; data registers are not reset.
module utc_time_mjd_bcd_decode_core import utcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  utcd_in_if.sink    in_i,
  utcd_out_if.source out_o
);

  localparam int unsigned Stages = 6;

  typedef struct packed {
    logic [TimeW-1:0] hour;
    logic [TimeW-1:0] minute;
    logic [TimeW-1:0] second;
    logic             tvalid;
  } time_t;

  // Two BCD digits to their weighted sum; nibbles above nine pass through.
  function automatic logic [TimeW-1:0] bcd_pair(input logic [7:0] b);
    return TimeW'({b[7:4], 3'b000}) + TimeW'({b[7:4], 1'b0}) + TimeW'(b[3:0]);
  endfunction

  logic                 adv;
  logic [Stages-1:0]    vld_q;
  time_t                time_d;
  time_t [Stages-1:0]   time_q;
  logic [YearW-1:0]     year;
  logic [MonthW-1:0]    month;
  logic [DayW-1:0]      day;
  logic                 dvalid;

  // The whole pipeline moves when the output register is free or drained.
  assign adv        = !vld_q[Stages-1] || out_o.ready;
  assign in_i.ready = adv;

  // Valid bits travel alongside the data stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Stages-2:0], in_i.valid};
    end
  end

  // Time fields are decoded on entry and delayed to match the date.
  assign time_d.hour   = bcd_pair(in_i.data.bcd_time[23:16]);
  assign time_d.minute = bcd_pair(in_i.data.bcd_time[15:8]);
  assign time_d.second = bcd_pair(in_i.data.bcd_time[7:0]);
  assign time_d.tvalid = (in_i.data.bcd_time != '0);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      time_q <= {time_q[Stages-2:0], time_d};
    end
  end

  utcd_date_pipe u_date (
    .clk_i        (clk_i),
    .en_i         (adv),
    .mjd_i        (in_i.data.mjd_value),
    .year_o       (year),
    .month_o      (month),
    .day_o        (day),
    .date_valid_o (dvalid)
  );

  // Result assembly.
  assign out_o.valid           = vld_q[Stages-1];
  assign out_o.data.year_out   = year;
  assign out_o.data.month_out  = month;
  assign out_o.data.day_out    = day;
  assign out_o.data.hour_out   = time_q[Stages-1].hour;
  assign out_o.data.minute_out = time_q[Stages-1].minute;
  assign out_o.data.second_out = time_q[Stages-1].second;
  assign out_o.data.date_valid = dvalid;
  assign out_o.data.time_valid = time_q[Stages-1].tvalid;

  // A valid date always lands on a real month and day.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.date_valid |->
      out_o.data.month_out >= MonthW'(1) && out_o.data.month_out <= MonthW'(12) &&
      out_o.data.day_out >= DayW'(1))
    else $error("valid date decoded to an impossible month or day");

  // An invalid date carries the fixed default fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.data.date_valid |->
      out_o.data.year_out == YearW'(YearBase) && out_o.data.month_out == '0 &&
      out_o.data.day_out == '0)
    else $error("invalid date with nonzero calendar fields");

  // An all-zero time word decodes to midnight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.data.time_valid |->
      out_o.data.hour_out == '0 && out_o.data.minute_out == '0 &&
      out_o.data.second_out == '0)
    else $error("zero time word produced nonzero time fields");

  // A stalled result stays in the output register until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> vld_q[Stages-1])
    else $error("stalled result vanished from the output register");

endmodule
